/* rtl/mtct_pkg.sv */
package mtct_pkg;

    localparam int TOK_W  = 24;
    localparam int KIND_W = 3;
    localparam int MODE_W = 3;
    localparam int SKIP_W = 3;

    localparam logic [KIND_W-1:0] K_CONTENT   = 3'd0;
    localparam logic [KIND_W-1:0] K_COMPONENT = 3'd1;
    localparam logic [KIND_W-1:0] K_COMMENT   = 3'd2;
    localparam logic [KIND_W-1:0] K_END       = 3'd3;
    localparam logic [KIND_W-1:0] K_ILLEGAL   = 3'd4;

    localparam logic [MODE_W-1:0] M_INITIAL   = 3'd0;
    localparam logic [MODE_W-1:0] M_CONTENT   = 3'd1;
    localparam logic [MODE_W-1:0] M_COMPONENT = 3'd2;
    localparam logic [MODE_W-1:0] M_COMMENT   = 3'd3;
    localparam logic [MODE_W-1:0] M_TAIL      = 3'd4;

    localparam logic [SKIP_W-1:0] SKIP_CONTENT   = 3'd1;
    localparam logic [SKIP_W-1:0] SKIP_COMMENT   = 3'd4;
    localparam logic [SKIP_W-1:0] SKIP_COMPONENT = 3'd5;
    localparam logic [SKIP_W-1:0] SKIP_TAIL      = 3'd2;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SKIP_W-1:0] skip;
        logic [TOK_W-1:0]  tbegin;
    } t_scan;

    typedef struct packed {
        logic              emit;
        logic [KIND_W-1:0] kind;
        logic [TOK_W-1:0]  start;
        logic [TOK_W-1:0]  len;
        logic              consume;
        logic              cut;
    } t_step;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TOK_W-1:0]  start;
        logic [TOK_W-1:0]  len;
        logic              last;
    } t_res;

    function automatic logic [7:0] lc(input logic [7:0] c);
        return c | CASE_BIT;
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_FF) || (c == CH_LF) || (c == CH_CR) ||
               (c == CH_TAB) || (c == CH_VT) || (c == CH_SLASH) || (c == CH_GT);
    endfunction

endpackage

/* rtl/mtct_step.sv */
module mtct_step #(
    parameter int LOOKAHEAD_BYTES = 10
) (
    input  logic [LOOKAHEAD_BYTES-1:0][7:0]         i_win,
    input  logic [$clog2(LOOKAHEAD_BYTES+1)-1:0]    i_fill,
    input  logic [mtct_pkg::TOK_W-1:0]              i_cursor,
    input  mtct_pkg::t_scan                         i_scan,
    output mtct_pkg::t_scan                         o_next,
    output mtct_pkg::t_step                         o_step
);

    localparam int FILL_W = $clog2(LOOKAHEAD_BYTES + 1);

    logic [LOOKAHEAD_BYTES-1:0][7:0] la;
    logic [7:0]                      b;
    logic [mtct_pkg::MODE_W-1:0]     m0;
    logic [mtct_pkg::MODE_W-1:0]     m1;
    logic                            pre_emit;
    logic                            cat_hit;
    logic                            doc_hit;
    logic                            head_hit;
    logic                            body_hit;
    logic                            comp_start;

    always_comb begin
        for (int k = 0; k < LOOKAHEAD_BYTES; k++) begin
            la[k] = (FILL_W'(k) < i_fill) ? i_win[k] : 8'h00;
        end
    end

    assign b = la[0];

    assign cat_hit  = (mtct_pkg::lc(la[1]) == "c") && (mtct_pkg::lc(la[2]) == "a") &&
                      (mtct_pkg::lc(la[3]) == "t") && (la[4] == mtct_pkg::CH_DASH);
    assign doc_hit  = (mtct_pkg::lc(la[1]) == "d") && (mtct_pkg::lc(la[2]) == "o") &&
                      (mtct_pkg::lc(la[3]) == "c") && (mtct_pkg::lc(la[4]) == "u") &&
                      (mtct_pkg::lc(la[5]) == "m") && (mtct_pkg::lc(la[6]) == "e") &&
                      (mtct_pkg::lc(la[7]) == "n") && (mtct_pkg::lc(la[8]) == "t") &&
                      mtct_pkg::is_sep(la[9]);
    assign head_hit = (mtct_pkg::lc(la[1]) == "h") && (mtct_pkg::lc(la[2]) == "e") &&
                      (mtct_pkg::lc(la[3]) == "a") && (mtct_pkg::lc(la[4]) == "d") &&
                      mtct_pkg::is_sep(la[5]);
    assign body_hit = (mtct_pkg::lc(la[1]) == "b") && (mtct_pkg::lc(la[2]) == "o") &&
                      (mtct_pkg::lc(la[3]) == "d") && (mtct_pkg::lc(la[4]) == "y") &&
                      mtct_pkg::is_sep(la[5]);
    assign comp_start = (b == mtct_pkg::CH_LT) && (cat_hit || doc_hit || head_hit || body_hit);

    assign m0 = (i_scan.mode == mtct_pkg::M_TAIL && i_scan.skip == '0) ?
                mtct_pkg::M_INITIAL : i_scan.mode;
    assign pre_emit = (m0 == mtct_pkg::M_CONTENT) && (i_scan.skip == '0) &&
                      (b == mtct_pkg::CH_LT);
    assign m1 = pre_emit ? mtct_pkg::M_INITIAL : m0;

    always_comb begin
        o_next         = i_scan;
        o_next.mode    = m1;
        o_step.emit    = pre_emit;
        o_step.kind    = mtct_pkg::K_CONTENT;
        o_step.start   = i_scan.tbegin;
        o_step.len     = i_cursor - i_scan.tbegin;
        o_step.consume = 1'b0;
        o_step.cut     = 1'b0;

        priority if (m1 == mtct_pkg::M_INITIAL) begin
            o_next.tbegin  = i_cursor;
            o_step.consume = 1'b1;
            priority if (b == mtct_pkg::CH_LT && la[1] == mtct_pkg::CH_BANG &&
                         la[2] == mtct_pkg::CH_DASH && la[3] == mtct_pkg::CH_DASH) begin
                o_next.mode = mtct_pkg::M_COMMENT;
                o_next.skip = mtct_pkg::SKIP_COMMENT - 3'd1;
            end else if (b == mtct_pkg::CH_LT && la[1] == mtct_pkg::CH_BANG) begin
                o_next.mode = mtct_pkg::M_CONTENT;
                o_next.skip = mtct_pkg::SKIP_CONTENT - 3'd1;
            end else if (comp_start) begin
                o_next.mode = mtct_pkg::M_COMPONENT;
                o_next.skip = mtct_pkg::SKIP_COMPONENT - 3'd1;
            end else begin
                o_next.mode = mtct_pkg::M_CONTENT;
                o_next.skip = mtct_pkg::SKIP_CONTENT - 3'd1;
            end
        end else if (m1 == mtct_pkg::M_TAIL) begin
            o_step.consume = 1'b1;
            o_next.skip    = i_scan.skip - 3'd1;
            if (i_scan.skip == 3'd1) begin
                o_next.mode = mtct_pkg::M_INITIAL;
            end
        end else if (i_scan.skip != '0) begin
            o_step.consume = 1'b1;
            o_next.skip    = i_scan.skip - 3'd1;
        end else if (m1 == mtct_pkg::M_COMPONENT) begin
            o_step.consume = 1'b1;
            if (b == mtct_pkg::CH_GT) begin
                o_step.emit = 1'b1;
                o_step.kind = mtct_pkg::K_COMPONENT;
                o_step.len  = i_cursor + 24'd1 - i_scan.tbegin;
                o_next.mode = mtct_pkg::M_INITIAL;
            end
        end else if (m1 == mtct_pkg::M_COMMENT) begin
            priority if (b == mtct_pkg::CH_DASH && i_fill < FILL_W'(3)) begin
                o_step.emit = 1'b1;
                o_step.cut  = 1'b1;
                o_step.kind = mtct_pkg::K_COMMENT;
            end else if (b == mtct_pkg::CH_DASH && la[1] == mtct_pkg::CH_DASH &&
                         la[2] == mtct_pkg::CH_GT) begin
                o_step.consume = 1'b1;
                o_step.emit    = 1'b1;
                o_step.kind    = mtct_pkg::K_COMMENT;
                o_step.len     = i_cursor + 24'd3 - i_scan.tbegin;
                o_next.mode    = mtct_pkg::M_TAIL;
                o_next.skip    = mtct_pkg::SKIP_TAIL;
            end else begin
                o_step.consume = 1'b1;
            end
        end else begin
            o_step.consume = 1'b1;
        end
    end

endmodule

/* rtl/markup_tag_comment_tokenizer.sv */
// Channel  Dir  Payload
// s_axis   in   tdata[7:0] text_byte; tuser[0] action
// m_axis   out  tdata[23:0] token_start, tdata[47:24] token_length;
//               tuser[2:0] token_kind; tlast last_of_run
//
// A text byte gives at most one token; once the window is full, the scanner
// consumes one window byte per cycle while text bytes are accepted.
// At end of text the same single-step scanner walks the remaining window
// bytes, one per cycle unless the skid entry is full, with s_axis_tready low.
// A two-entry output stage (register plus skid) keeps s_axis open while one
// result waits; s_axis_tready is low while the skid entry is full or during end of text.
// Reset is synchronous and clears control state; window bytes are not reset.
module markup_tag_comment_tokenizer #(
    parameter int LOOKAHEAD_BYTES = 10,
    parameter int MAX_TEXT_BYTES  = 16777216
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic [0:0]  s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [23:0] token_start, [47:24] token_length
    output logic [2:0]  m_axis_tuser,   // [2:0] token_kind
    output logic        m_axis_tlast    // last_of_run
);

    localparam int FILL_W = $clog2(LOOKAHEAD_BYTES + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(LOOKAHEAD_BYTES);
    localparam logic [mtct_pkg::TOK_W-1:0] POS_LIMIT =
        mtct_pkg::TOK_W'(MAX_TEXT_BYTES - 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_STEP = 2'd1;
    localparam logic [1:0] PH_ILL  = 2'd2;
    localparam logic [1:0] PH_END  = 2'd3;

    logic [LOOKAHEAD_BYTES-1:0][7:0] r_win;
    logic [LOOKAHEAD_BYTES-1:0][7:0] n_win;
    logic [FILL_W-1:0]               r_fill;
    logic [FILL_W-1:0]               n_fill;
    mtct_pkg::t_scan                 r_scan;
    mtct_pkg::t_scan                 n_scan;
    logic [mtct_pkg::TOK_W-1:0]      r_pos;
    logic [mtct_pkg::TOK_W-1:0]      n_pos;
    logic                            r_term;
    logic                            n_term;
    logic [1:0]                      r_ph;
    logic [1:0]                      n_ph;

    logic                            r_out_valid;
    mtct_pkg::t_res                  r_out;
    logic                            r_skid_valid;
    mtct_pkg::t_res                  r_skid;

    logic [LOOKAHEAD_BYTES-1:0][7:0] win_app;
    logic [LOOKAHEAD_BYTES-1:0][7:0] st_win;
    logic [LOOKAHEAD_BYTES-1:0][7:0] win_shift;
    logic [FILL_W-1:0]               st_fill;
    logic [mtct_pkg::TOK_W-1:0]      cursor;
    mtct_pkg::t_scan                 st_next;
    mtct_pkg::t_step                 st_out;

    logic                            acc;
    logic                            gen_ok;
    logic                            out_take;
    logic                            res_valid;
    mtct_pkg::t_res                  res;

    assign s_axis_tready = (r_ph == PH_IDLE) && !r_skid_valid;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign gen_ok        = !r_skid_valid;
    assign out_take      = r_out_valid && m_axis_tready;

    always_comb begin
        for (int k = 0; k < LOOKAHEAD_BYTES; k++) begin
            win_app[k] = (FILL_W'(k) == r_fill) ? s_axis_tdata : r_win[k];
        end
    end

    assign st_win  = (r_ph == PH_IDLE) ? win_app : r_win;
    assign st_fill = (r_ph == PH_IDLE) ? r_fill + FILL_W'(1) : r_fill;
    assign cursor  = r_pos - mtct_pkg::TOK_W'(r_fill);

    always_comb begin
        for (int k = 0; k < LOOKAHEAD_BYTES - 1; k++) begin
            win_shift[k] = st_win[k + 1];
        end
        win_shift[LOOKAHEAD_BYTES-1] = st_win[LOOKAHEAD_BYTES-1];
    end

    mtct_step #(
        .LOOKAHEAD_BYTES (LOOKAHEAD_BYTES)
    ) u_step (
        .i_win    (st_win),
        .i_fill   (st_fill),
        .i_cursor (cursor),
        .i_scan   (r_scan),
        .o_next   (st_next),
        .o_step   (st_out)
    );

    always_comb begin
        n_win     = r_win;
        n_fill    = r_fill;
        n_scan    = r_scan;
        n_pos     = r_pos;
        n_term    = r_term;
        n_ph      = r_ph;
        res_valid = 1'b0;
        res       = '0;

        if (acc) begin
            if (s_axis_tuser[0] == 1'b0) begin
                if (!r_term) begin
                    if (r_pos >= POS_LIMIT) begin
                        res_valid = 1'b1;
                        res.kind  = mtct_pkg::K_ILLEGAL;
                        res.last  = 1'b1;
                        n_term    = 1'b1;
                    end else begin
                        n_win  = win_app;
                        n_fill = r_fill + FILL_W'(1);
                        n_pos  = r_pos + 24'd1;
                        if (r_fill + FILL_W'(1) == FILL_FULL) begin
                            n_scan = st_next;
                            if (st_out.consume) begin
                                n_win  = win_shift;
                                n_fill = r_fill;
                            end
                            if (st_out.emit) begin
                                res_valid = 1'b1;
                                res.kind  = st_out.kind;
                                res.start = st_out.start;
                                res.len   = st_out.len;
                                res.last  = 1'b1;
                            end
                        end
                    end
                end
            end else if (r_term) begin
                n_fill = '0;
                n_scan = '{mode: mtct_pkg::M_INITIAL, skip: '0, tbegin: '0};
                n_pos  = '0;
                n_term = 1'b0;
            end else begin
                n_ph = PH_STEP;
            end
        end else if (gen_ok) begin
            unique case (r_ph)
                PH_IDLE: begin
                end
                PH_STEP: begin
                    if (r_fill != '0) begin
                        n_scan = st_next;
                        if (st_out.consume) begin
                            n_win  = win_shift;
                            n_fill = r_fill - FILL_W'(1);
                        end
                        res_valid = st_out.emit;
                        res.kind  = st_out.kind;
                        res.start = st_out.start;
                        res.len   = st_out.len;
                        if (st_out.cut) begin
                            n_ph = PH_ILL;
                        end
                    end else begin
                        res_valid = 1'b1;
                        res.start = r_scan.tbegin;
                        res.len   = r_pos - r_scan.tbegin;
                        unique case (r_scan.mode)
                            mtct_pkg::M_CONTENT: begin
                                res.kind = mtct_pkg::K_CONTENT;
                                n_ph     = PH_END;
                            end
                            mtct_pkg::M_COMPONENT: begin
                                res.kind = mtct_pkg::K_COMPONENT;
                                n_ph     = PH_ILL;
                            end
                            mtct_pkg::M_COMMENT: begin
                                res.kind = mtct_pkg::K_COMMENT;
                                n_ph     = PH_ILL;
                            end
                            default: begin
                                res.kind  = mtct_pkg::K_END;
                                res.start = '0;
                                res.len   = '0;
                                res.last  = 1'b1;
                                n_ph      = PH_IDLE;
                                n_fill    = '0;
                                n_scan    = '{mode: mtct_pkg::M_INITIAL, skip: '0, tbegin: '0};
                                n_pos     = '0;
                                n_term    = 1'b0;
                            end
                        endcase
                    end
                end
                PH_ILL, PH_END: begin
                    res_valid = 1'b1;
                    res.kind  = (r_ph == PH_ILL) ? mtct_pkg::K_ILLEGAL : mtct_pkg::K_END;
                    res.last  = 1'b1;
                    n_ph      = PH_IDLE;
                    n_fill    = '0;
                    n_scan    = '{mode: mtct_pkg::M_INITIAL, skip: '0, tbegin: '0};
                    n_pos     = '0;
                    n_term    = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (!i_rst_n) begin
            r_fill <= '0;
            r_scan <= '{mode: mtct_pkg::M_INITIAL, skip: '0, tbegin: '0};
            r_pos  <= '0;
            r_term <= 1'b0;
            r_ph   <= PH_IDLE;
        end else begin
            r_fill <= n_fill;
            r_scan <= n_scan;
            r_pos  <= n_pos;
            r_term <= n_term;
            r_ph   <= n_ph;
        end
    end

    // hold a result in the skid entry while the output register is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.len, r_out.start};
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;

endmodule
